### rtl/core/stcf_pkg.sv
// ----------------------------------------------------------------------------
// stcf_pkg
// Shared types, codes and byte tables for the Swedish text charset filter.
// ----------------------------------------------------------------------------
package stcf_pkg;

  // Input item and result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Character set modes. Codes 5 to 7 map nothing.
  typedef enum logic [2:0] {
    CS_NONE     = 3'd0,
    CS_UTF8     = 3'd1,
    CS_IBM437   = 3'd2,
    CS_LATIN1   = 3'd3,
    CS_MACROMAN = 3'd4
  } charset_e;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_CHARSET_MODE = 2'd0;
  localparam logic [1:0] REG_ANSI_AWARE   = 2'd1;
  localparam logic [1:0] REG_PASS_BELL    = 2'd2;
  localparam logic [1:0] REG_ROT13_ENABLE = 2'd3;

  localparam logic [7:0] CH_BEL     = 8'h07;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] UTF8_LEAD  = 8'hC3;

  // Swedish letter slots; SW_NONE marks a byte that is none of them.
  localparam logic [2:0] SW_A_RING_LO  = 3'd0;
  localparam logic [2:0] SW_A_UML_LO   = 3'd1;
  localparam logic [2:0] SW_O_UML_LO   = 3'd2;
  localparam logic [2:0] SW_A_RING_UP  = 3'd3;
  localparam logic [2:0] SW_A_UML_UP   = 3'd4;
  localparam logic [2:0] SW_O_UML_UP   = 3'd5;
  localparam logic [2:0] SW_NONE       = 3'd6;

  // Result of translating one accepted byte.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       escape_pending;
    logic       inside_escape;
  } xlate_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A]}) || (b inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic [7:0] rot13(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if ((b inside {[8'h41:8'h4D]}) || (b inside {[8'h61:8'h6D]})) begin
      r = b + 8'd13;
    end else if ((b inside {[8'h4E:8'h5A]}) || (b inside {[8'h6E:8'h7A]})) begin
      r = b - 8'd13;
    end
    return r;
  endfunction

  function automatic logic [2:0] swedish_index(input logic [7:0] b);
    logic [2:0] s;
    case (b)
      8'h7D:   s = SW_A_RING_LO;
      8'h7B:   s = SW_A_UML_LO;
      8'h7C:   s = SW_O_UML_LO;
      8'h5D:   s = SW_A_RING_UP;
      8'h5B:   s = SW_A_UML_UP;
      8'h5C:   s = SW_O_UML_UP;
      default: s = SW_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] utf8_second(input logic [2:0] s);
    logic [7:0] r;
    case (s)
      SW_A_RING_LO: r = 8'hA5;
      SW_A_UML_LO:  r = 8'hA4;
      SW_O_UML_LO:  r = 8'hB6;
      SW_A_RING_UP: r = 8'h85;
      SW_A_UML_UP:  r = 8'h84;
      default:      r = 8'h96;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ibm437_byte(input logic [2:0] s);
    logic [7:0] r;
    case (s)
      SW_A_RING_LO: r = 8'd134;
      SW_A_UML_LO:  r = 8'd132;
      SW_O_UML_LO:  r = 8'd148;
      SW_A_RING_UP: r = 8'd143;
      SW_A_UML_UP:  r = 8'd142;
      default:      r = 8'd153;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] latin1_byte(input logic [2:0] s);
    logic [7:0] r;
    case (s)
      SW_A_RING_LO: r = 8'd229;
      SW_A_UML_LO:  r = 8'd228;
      SW_O_UML_LO:  r = 8'd246;
      SW_A_RING_UP: r = 8'd197;
      SW_A_UML_UP:  r = 8'd196;
      default:      r = 8'd214;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] macroman_byte(input logic [2:0] s);
    logic [7:0] r;
    case (s)
      SW_A_RING_LO: r = 8'd140;
      SW_A_UML_LO:  r = 8'd138;
      SW_O_UML_LO:  r = 8'd154;
      SW_A_RING_UP: r = 8'd129;
      SW_A_UML_UP:  r = 8'd128;
      default:      r = 8'd133;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/stcf_xlate.sv
// ----------------------------------------------------------------------------
// stcf_xlate
// Translates one byte: bell drop, CSI tracking, LF expansion, charset mapping
// and ROT13. Pure combinational; the caller holds the escape flags.
// ----------------------------------------------------------------------------
module stcf_xlate (
  input  stcf_pkg::in_item_t item_i,
  input  logic               escape_pending_i,
  input  logic               inside_escape_i,
  input  logic [2:0]         charset_mode_i,
  input  logic               ansi_aware_i,
  input  logic               pass_bell_i,
  input  logic               rot13_enable_i,
  output stcf_pkg::xlate_t   xlate_o
);

  logic [7:0] b;
  logic       pend;
  logic       ins;
  logic       ins_d;
  logic [2:0] sw;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [1:0] count;

  assign b  = item_i.data_byte;
  assign sw = stcf_pkg::swedish_index(b);

  always_comb begin
    // Start of message clears escape tracking before this byte.
    pend  = escape_pending_i & ~item_i.start_of_message;
    ins   = inside_escape_i & ~item_i.start_of_message;
    ins_d = ins;
    byte0 = b;
    byte1 = stcf_pkg::CH_LF;
    count = 2'd1;
    xlate_o.escape_pending = 1'b0;

    if (b == stcf_pkg::CH_BEL && !pass_bell_i) begin
      // Drop the bell; keep sequence state, forget a pending ESC.
      count = 2'd0;
    end else begin
      if (ansi_aware_i) begin
        if (pend && b == stcf_pkg::CH_LBRACK) begin
          ins_d = 1'b1;
        end else if (ins && stcf_pkg::is_letter(b)) begin
          ins_d = 1'b0;
        end
        xlate_o.escape_pending = (b == stcf_pkg::CH_ESC);
      end else begin
        ins_d = 1'b0;
      end

      if (b == stcf_pkg::CH_LF) begin
        byte0 = stcf_pkg::CH_CR;
        byte1 = stcf_pkg::CH_LF;
        count = 2'd2;
      end else if (!ins_d && sw != stcf_pkg::SW_NONE) begin
        case (charset_mode_i)
          stcf_pkg::CS_UTF8: begin
            byte0 = stcf_pkg::UTF8_LEAD;
            byte1 = stcf_pkg::utf8_second(sw);
            count = 2'd2;
          end
          stcf_pkg::CS_IBM437:   byte0 = stcf_pkg::ibm437_byte(sw);
          stcf_pkg::CS_LATIN1:   byte0 = stcf_pkg::latin1_byte(sw);
          stcf_pkg::CS_MACROMAN: byte0 = stcf_pkg::macroman_byte(sw);
          default:               byte0 = b;
        endcase
      end
    end

    xlate_o.inside_escape = ins_d;
    xlate_o.count         = count;
    xlate_o.byte0         = rot13_enable_i ? stcf_pkg::rot13(byte0) : byte0;
    xlate_o.byte1         = rot13_enable_i ? stcf_pkg::rot13(byte1) : byte1;
  end

endmodule

### rtl/core/swedish_text_charset_filter_unit.sv
// ----------------------------------------------------------------------------
// swedish_text_charset_filter_unit
// Swedish 7-bit text to terminal byte filter with an APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one text byte per
//   transfer plus a start-of-message flag. Output channel
//   (out_valid_o/out_ready_i/out_data_o) gives zero, one or two terminal
//   bytes per input byte; last_of_run marks the final one of each run.
//   A dropped bell gives no output at all.
//   A byte passes from the input register to the result buffer, which
//   drives the output. Throughput: one output byte per cycle while
//   out_ready_i is high, set by the single output port of the two-entry
//   result buffer; a pair (CR LF or a UTF-8 letter) gives two bytes.
//   Stall: while the receiver holds out_ready_i low the result buffer holds
//   its bytes, one more input byte waits in the input register, and then
//   in_ready_o drops.
//   Reset: clears the configuration to zero (no mapping, ANSI tracking off,
//   bells dropped, ROT13 off), the escape flags and both buffers.
//   Configuration: registers at byte addresses 0, 4, 8 and 12; write only
//   while the block is idle. pready is always high.
// ----------------------------------------------------------------------------
module swedish_text_charset_filter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stcf_pkg::in_item_t  in_data_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stcf_pkg::out_item_t out_data_o,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers
  logic [2:0] charset_mode_q;
  logic       ansi_aware_q;
  logic       pass_bell_q;
  logic       rot13_enable_q;
  logic       cfg_write;
  logic [1:0] cfg_index;

  // Input register
  logic                s1_valid_q;
  stcf_pkg::in_item_t  s1_data_q;
  logic                s1_move;
  logic                in_fire;

  // Escape tracking
  logic escape_pending_q;
  logic inside_escape_q;

  // Result buffer: up to two bytes, slot 0 is the head
  stcf_pkg::out_item_t [1:0] slot_q;
  logic [1:0]                cnt_q;
  logic [1:0]                cnt_d;
  logic                      pop;
  logic                      out_space;
  logic                      load;

  stcf_pkg::xlate_t xlate;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charset_mode_q <= stcf_pkg::CS_NONE;
      ansi_aware_q   <= 1'b0;
      pass_bell_q    <= 1'b0;
      rot13_enable_q <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        stcf_pkg::REG_CHARSET_MODE: charset_mode_q <= pwdata[2:0];
        stcf_pkg::REG_ANSI_AWARE:   ansi_aware_q   <= pwdata[0];
        stcf_pkg::REG_PASS_BELL:    pass_bell_q    <= pwdata[0];
        stcf_pkg::REG_ROT13_ENABLE: rot13_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_index)
      stcf_pkg::REG_CHARSET_MODE: prdata[2:0] = charset_mode_q;
      stcf_pkg::REG_ANSI_AWARE:   prdata[0]   = ansi_aware_q;
      stcf_pkg::REG_PASS_BELL:    prdata[0]   = pass_bell_q;
      stcf_pkg::REG_ROT13_ENABLE: prdata[0]   = rot13_enable_q;
      default:                    prdata      = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Translation of the byte held in the input register
  // --------------------------------------------------------------------------
  stcf_xlate u_xlate (
    .item_i           (s1_data_q),
    .escape_pending_i (escape_pending_q),
    .inside_escape_i  (inside_escape_q),
    .charset_mode_i   (charset_mode_q),
    .ansi_aware_i     (ansi_aware_q),
    .pass_bell_i      (pass_bell_q),
    .rot13_enable_i   (rot13_enable_q),
    .xlate_o          (xlate)
  );

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  assign pop       = out_valid_o & out_ready_i;
  // The buffer can take a fresh run if it is empty or drains this cycle.
  assign out_space = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & out_ready_i);
  // A dropped byte needs no buffer space.
  assign s1_move   = s1_valid_q & ((xlate.count == 2'd0) | out_space);
  assign load      = s1_move & (xlate.count != 2'd0);
  assign in_ready_o = ~s1_valid_q | s1_move;
  assign in_fire    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
  end

  // Advance the escape flags once per byte that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_pending_q <= 1'b0;
      inside_escape_q  <= 1'b0;
    end else if (s1_move) begin
      escape_pending_q <= xlate.escape_pending;
      inside_escape_q  <= xlate.inside_escape;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer
  // --------------------------------------------------------------------------
  always_comb begin
    if (load) begin
      cnt_d = xlate.count;
    end else begin
      cnt_d = cnt_q - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q[0].out_byte    <= xlate.byte0;
      slot_q[0].last_of_run <= (xlate.count == 2'd1);
      slot_q[1].out_byte    <= xlate.byte1;
      slot_q[1].last_of_run <= 1'b1;
    end else if (pop) begin
      // Shift the second byte of a pair to the head.
      slot_q[0] <= slot_q[1];
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];

endmodule

### rtl/core/stcf_checker.sv
// ----------------------------------------------------------------------------
// stcf_checker
// Port-level checks for the Swedish text charset filter, bound to the top.
// ----------------------------------------------------------------------------
module stcf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input stcf_pkg::out_item_t out_data_o
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // Input only stalls behind a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result buffer");

  // The second byte of a pair is ready right after the first.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("second byte of a pair missing");

  // A run opens only with CR or the UTF-8 lead byte.
  a_pair_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |->
      (out_data_o.out_byte == stcf_pkg::CH_CR) ||
      (out_data_o.out_byte == stcf_pkg::UTF8_LEAD))
    else $error("unexpected first byte of a pair");

endmodule

bind swedish_text_charset_filter_unit stcf_checker u_stcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte filter check: charset mapping, CSI tracking, bell, CR LF and ROT13.
// A directed table walks the corner cases, then random text phases with
// well-formed and broken escape sequences run under random stalls on both
// channels. Every output transfer is checked against the table or a behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 190;
  localparam int PREDICT        = -1;

  // Byte tables, slot 0 in the low byte: a-ring, a-uml, o-uml, A-ring, A-uml, O-uml.
  localparam logic [47:0] UTF8_TAIL  = {8'h96, 8'h84, 8'h85, 8'hB6, 8'hA4, 8'hA5};
  localparam logic [47:0] IBM437_ROW = {8'd153, 8'd142, 8'd143, 8'd148, 8'd132, 8'd134};
  localparam logic [47:0] LATIN1_ROW = {8'd214, 8'd196, 8'd197, 8'd246, 8'd228, 8'd229};
  localparam logic [47:0] MACROM_ROW = {8'd133, 8'd128, 8'd129, 8'd154, 8'd138, 8'd140};

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [2:0]         mode;
    logic               ansi;
    logic               bell;
    logic               rot;
    stcf_pkg::in_item_t item;
    int                 count;   // PREDICT, or the number of typed results
    logic [7:0]         b0;
    logic [7:0]         b1;
  } dir_row_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  stcf_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  stcf_pkg::out_item_t out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [3:0]          paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Predictor copy of configuration and escape state.
  logic [2:0]  cfg_mode = stcf_pkg::CS_NONE;
  logic        cfg_ansi = 1'b0;
  logic        cfg_bell = 1'b0;
  logic        cfg_rot  = 1'b0;
  logic        esc_seen = 1'b0;
  logic        in_csi   = 1'b0;

  stcf_pkg::out_item_t terminal_bytes_due[$];
  logic [7:0]          text_plan[$];
  dir_row_t            directed[$];
  int                  errors       = 0;
  int                  quiet_cycles = 0;
  int                  stall_left   = 0;
  bit                  tx_calm      = 1'b0;
  bit                  rx_calm      = 1'b0;

  swedish_text_charset_filter_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic bit ascii_alpha(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic [7:0] rot_letter(input logic [7:0] b);
    logic [7:0] base;
    if (!cfg_rot || !ascii_alpha(b)) return b;
    base = (b <= "Z") ? "A" : "a";
    return base + ((b - base + 8'd13) % 8'd26);
  endfunction

  // Slot of a Swedish 7-bit letter, -1 for any other byte.
  function automatic int swedish_slot(input logic [7:0] b);
    case (b)
      8'h7D:   return 0;
      8'h7B:   return 1;
      8'h7C:   return 2;
      8'h5D:   return 3;
      8'h5B:   return 4;
      8'h5C:   return 5;
      default: return -1;
    endcase
  endfunction

  // Advance the escape state by one input byte; return the result count.
  function automatic int filter_text_byte(input stcf_pkg::in_item_t it,
                                          output logic [7:0] t0,
                                          output logic [7:0] t1);
    logic [7:0] b;
    int         slot;
    int         n;
    b  = it.data_byte;
    t0 = b;
    t1 = stcf_pkg::CH_LF;
    n  = 1;
    if (it.start_of_message) begin
      esc_seen = 1'b0;
      in_csi   = 1'b0;
    end
    // A dropped bell breaks a pending ESC but leaves an open sequence open.
    if (b == stcf_pkg::CH_BEL && !cfg_bell) begin
      esc_seen = 1'b0;
      return 0;
    end
    if (cfg_ansi) begin
      if (esc_seen && b == stcf_pkg::CH_LBRACK) begin
        in_csi = 1'b1;
      end else if (in_csi && ascii_alpha(b)) begin
        in_csi = 1'b0;
      end
      esc_seen = (b == stcf_pkg::CH_ESC);
    end else begin
      esc_seen = 1'b0;
      in_csi   = 1'b0;
    end
    slot = swedish_slot(b);
    if (b == stcf_pkg::CH_LF) begin
      t0 = stcf_pkg::CH_CR;
      n  = 2;
    end else if (!in_csi && slot >= 0) begin
      case (cfg_mode)
        stcf_pkg::CS_UTF8: begin
          t0 = stcf_pkg::UTF8_LEAD;
          t1 = UTF8_TAIL[slot*8 +: 8];
          n  = 2;
        end
        stcf_pkg::CS_IBM437:   t0 = IBM437_ROW[slot*8 +: 8];
        stcf_pkg::CS_LATIN1:   t0 = LATIN1_ROW[slot*8 +: 8];
        stcf_pkg::CS_MACROMAN: t0 = MACROM_ROW[slot*8 +: 8];
        default: ;
      endcase
    end
    t0 = rot_letter(t0);
    t1 = rot_letter(t1);
    return n;
  endfunction

  // ------------------------------------------------------------------------
  // Idle lengths and text generation
  // ------------------------------------------------------------------------
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (tx_calm || $urandom_range(0, 99) < 55) return 0;
    return pick_idle_len();
  endfunction

  function automatic logic [7:0] swedish_char();
    case ($urandom_range(0, 5))
      0:       return 8'h7D;
      1:       return 8'h7B;
      2:       return 8'h7C;
      3:       return 8'h5D;
      4:       return 8'h5B;
      default: return 8'h5C;
    endcase
  endfunction

  function automatic logic [7:0] random_letter();
    int k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'h41 + k[7:0] : 8'h61 + k[7:0] - 8'd26;
  endfunction

  // Queue up the next chunk of text: mostly plain text and letters, some CSI
  // sequences (a few of them broken), bells, line feeds and raw bytes.
  task automatic plan_text();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      text_plan.push_back(stcf_pkg::CH_ESC);
      if ($urandom_range(0, 99) < 85) begin
        text_plan.push_back(stcf_pkg::CH_LBRACK);
        repeat ($urandom_range(0, 4)) begin
          k = $urandom_range(0, 99);
          if (k < 70)      text_plan.push_back(8'h30 + 8'($urandom_range(0, 9)));
          else if (k < 80) text_plan.push_back(8'h3B);
          else if (k < 90) text_plan.push_back(swedish_char());
          else if (k < 95) text_plan.push_back(stcf_pkg::CH_LF);
          else             text_plan.push_back(stcf_pkg::CH_BEL);
        end
        if ($urandom_range(0, 99) < 85) text_plan.push_back(random_letter());
      end
    end else if (r < 40) begin
      text_plan.push_back(swedish_char());
    end else if (r < 48) begin
      text_plan.push_back(stcf_pkg::CH_LF);
    end else if (r < 54) begin
      text_plan.push_back(stcf_pkg::CH_BEL);
    end else if (r < 56) begin
      text_plan.push_back(stcf_pkg::CH_ESC);
    end else if (r < 80) begin
      text_plan.push_back(random_letter());
    end else if (r < 90) begin
      text_plan.push_back(8'($urandom_range(32, 126)));
    end else begin
      text_plan.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ------------------------------------------------------------------------
  // Channel and register port drivers
  // ------------------------------------------------------------------------
  // Hold the byte until transfer, then queue what it should produce.
  task automatic send_text_byte(input stcf_pkg::in_item_t it, input int gap, input int tn,
                                input logic [7:0] e0, input logic [7:0] e1);
    logic [7:0]          p0;
    logic [7:0]          p1;
    int                  pn;
    stcf_pkg::out_item_t r;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    pn = filter_text_byte(it, p0, p1);
    if (tn != PREDICT) begin
      pn = tn;
      p0 = e0;
      p1 = e1;
    end
    if (pn >= 1) begin
      r.out_byte    = p0;
      r.last_of_run = (pn == 1);
      terminal_bytes_due.push_back(r);
    end
    if (pn == 2) begin
      r.out_byte    = p1;
      r.last_of_run = 1'b1;
      terminal_bytes_due.push_back(r);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every due byte, then let a dropped bell clear out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (terminal_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
  endtask

  // Write all four registers, read them back, and mirror them in the predictor.
  task automatic program_filter(input logic [2:0] mode, input logic ansi, input logic bell,
                                input logic rot);
    logic [1:0]  regs [4];
    logic [31:0] vals [4];
    logic [31:0] masks [4];
    logic [31:0] rd;
    int          i;
    regs[0] = stcf_pkg::REG_CHARSET_MODE;  vals[0] = {29'd0, mode};  masks[0] = 32'h7;
    regs[1] = stcf_pkg::REG_ANSI_AWARE;    vals[1] = {31'd0, ansi};  masks[1] = 32'h1;
    regs[2] = stcf_pkg::REG_PASS_BELL;     vals[2] = {31'd0, bell};  masks[2] = 32'h1;
    regs[3] = stcf_pkg::REG_ROT13_ENABLE;  vals[3] = {31'd0, rot};   masks[3] = 32'h1;
    for (i = 0; i < 4; i++) apb_access(1'b1, regs[i], vals[i], rd);
    for (i = 0; i < 4; i++) begin
      apb_access(1'b0, regs[i], '0, rd);
      if ((rd & masks[i]) !== vals[i]) begin
        errors++;
        $display("%0t: register %0d read back, expected %0h, actual %0h",
                 $time, regs[i], vals[i], rd & masks[i]);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_mode = mode;
    cfg_ansi = ansi;
    cfg_bell = bell;
    cfg_rot  = rot;
  endtask

  // ------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      out_ready <= 1'b0;
      stall_left = pick_idle_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_out
    stcf_pkg::out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (terminal_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected output, expected none, actual %02h/%0b",
                 $time, out_data.out_byte, out_data.last_of_run);
      end else begin
        want = terminal_bytes_due.pop_front();
        if (want.out_byte !== out_data.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %02h, actual %02h",
                   $time, want.out_byte, out_data.out_byte);
        end
        if (want.last_of_run !== out_data.last_of_run) begin
          errors++;
          $display("%0t: last_of_run expected %0b, actual %0b",
                   $time, want.last_of_run, out_data.last_of_run);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Directed table and random phases
  // ------------------------------------------------------------------------
  function automatic dir_row_t cfg_row(input logic [2:0] m, input logic a, input logic b,
                                       input logic r);
    dir_row_t row;
    row.kind  = ROW_CFG;
    row.mode  = m;
    row.ansi  = a;
    row.bell  = b;
    row.rot   = r;
    row.item  = '0;
    row.count = PREDICT;
    row.b0    = '0;
    row.b1    = '0;
    return row;
  endfunction

  function automatic dir_row_t text_row(input logic [7:0] d, input logic som, input int n,
                                        input logic [7:0] e0, input logic [7:0] e1);
    dir_row_t row;
    row = cfg_row(stcf_pkg::CS_NONE, 1'b0, 1'b0, 1'b0);
    row.kind                  = ROW_BYTE;
    row.item.data_byte        = d;
    row.item.start_of_message = som;
    row.count                 = n;
    row.b0                    = e0;
    row.b1                    = e1;
    return row;
  endfunction

  initial begin : stimulus
    stcf_pkg::in_item_t it;
    int                 ph;
    int                 n;
    // Reset configuration: nothing mapped, bells dropped, extremes pass as is.
    directed.push_back(text_row(8'h41, 1'b1, 1, 8'h41, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_BEL, 1'b0, 0, 8'h00, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_LF, 1'b0, 2, stcf_pkg::CH_CR,
                                stcf_pkg::CH_LF));
    directed.push_back(text_row(8'h00, 1'b0, 1, 8'h00, 8'h00));
    directed.push_back(text_row(8'hFF, 1'b1, 1, 8'hFF, 8'h00));
    directed.push_back(text_row(8'h7D, 1'b0, 1, 8'h7D, 8'h00));
    // UTF-8 pairs with everything on: a full CSI sequence with LF inside it.
    directed.push_back(cfg_row(stcf_pkg::CS_UTF8, 1'b1, 1'b1, 1'b1));
    directed.push_back(text_row(8'h7D, 1'b0, 2, stcf_pkg::UTF8_LEAD, 8'hA5));
    directed.push_back(text_row(stcf_pkg::CH_BEL, 1'b0, 1, stcf_pkg::CH_BEL, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_ESC, 1'b0, 1, stcf_pkg::CH_ESC, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_LBRACK, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(8'h7C, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_LF, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(8'h6D, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(8'h5C, 1'b0, 2, stcf_pkg::UTF8_LEAD, 8'h96));
    // IBM437: a dropped bell between ESC and '[' opens no sequence, and a
    // start of message closes an open one.
    directed.push_back(cfg_row(stcf_pkg::CS_IBM437, 1'b1, 1'b0, 1'b0));
    directed.push_back(text_row(stcf_pkg::CH_ESC, 1'b0, 1, stcf_pkg::CH_ESC, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_BEL, 1'b0, 0, 8'h00, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_LBRACK, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_ESC, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(stcf_pkg::CH_LBRACK, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(8'h7B, 1'b1, PREDICT, 8'h00, 8'h00));
    // Unused mode maps nothing; ROT13 alone.
    directed.push_back(cfg_row(3'd7, 1'b0, 1'b0, 1'b1));
    directed.push_back(text_row(8'h7B, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(8'h61, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(text_row(8'h5A, 1'b0, PREDICT, 8'h00, 8'h00));
    directed.push_back(cfg_row(stcf_pkg::CS_LATIN1, 1'b0, 1'b1, 1'b0));
    directed.push_back(text_row(8'h5D, 1'b0, 1, 8'd197, 8'h00));
    directed.push_back(cfg_row(stcf_pkg::CS_MACROMAN, 1'b1, 1'b0, 1'b0));
    directed.push_back(text_row(8'h5C, 1'b0, 1, 8'd133, 8'h00));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_results();
        program_filter(directed[i].mode, directed[i].ansi, directed[i].bell, directed[i].rot);
      end else begin
        send_text_byte(directed[i].item, pick_gap(), directed[i].count,
                       directed[i].b0, directed[i].b1);
      end
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       program_filter(stcf_pkg::CS_NONE, 1'b0, 1'b0, 1'b0);
        1:       program_filter(3'd7, 1'b1, 1'b1, 1'b1);
        2:       program_filter(stcf_pkg::CS_UTF8, 1'b1, 1'($urandom), 1'($urandom));
        3:       program_filter(stcf_pkg::CS_IBM437, 1'b1, 1'($urandom), 1'($urandom));
        4:       program_filter(stcf_pkg::CS_LATIN1, 1'($urandom), 1'($urandom),
                                1'($urandom));
        5:       program_filter(stcf_pkg::CS_MACROMAN, 1'b1, 1'($urandom), 1'($urandom));
        default: program_filter(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
                                1'($urandom));
      endcase
      // Some phases run back to back on one side or the other.
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the sender once per phase until the output runs dry.
        if (n == PHASE_ITEMS / 2) drain_results();
        if (text_plan.size() == 0) plan_text();
        it.data_byte        = text_plan.pop_front();
        it.start_of_message = ($urandom_range(0, 99) < 3);
        send_text_byte(it, pick_gap(), PREDICT, 8'h00, 8'h00);
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/stcf_pkg.sv
rtl/core/stcf_xlate.sv
rtl/core/swedish_text_charset_filter_unit.sv
rtl/core/stcf_checker.sv
bench/testbench.sv
